// ===== rtl/stable_duplicate_filter_top_defines.svh =====
// Assertion macros used by the duplicate filter checker.
`ifndef STABLE_DUPLICATE_FILTER_TOP_DEFINES_SVH
`define STABLE_DUPLICATE_FILTER_TOP_DEFINES_SVH

// Clocked assertion, disabled while reset is asserted.
`define SDF_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define SDF_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/sdf_pkg.sv =====
// Shared widths and stream field layout of the duplicate filter.
package sdf_pkg;

  localparam int VALUE_W  = 32;
  localparam int COUNT_W  = 7;
  localparam int S_DATA_W = 32;
  localparam int M_DATA_W = 40;

  // Flags that travel on the result tuser, highest bit first.
  typedef struct packed {
    logic overflow;
    logic keep;
  } out_user_t;

  localparam int M_USER_W = $bits(out_user_t);

endpackage

// ===== rtl/sdf_cell.sv =====
// One store cell: holds a kept value, passes it down on insert, compares it to the probe.
module sdf_cell #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                  clk_i,
  input  logic                  shift_i,
  input  logic [DATA_WIDTH-1:0] data_i,
  input  logic [DATA_WIDTH-1:0] probe_i,
  input  logic                  active_i,
  output logic [DATA_WIDTH-1:0] data_o,
  output logic                  hit_o
);

  logic [DATA_WIDTH-1:0] value_q;
  logic [DATA_WIDTH-1:0] value_d;

  assign value_d = shift_i ? data_i : value_q;

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign data_o = value_q;
  assign hit_o  = active_i && (value_q == probe_i);

endmodule

// ===== rtl/stable_duplicate_filter_top.sv =====
// Order-preserving duplicate filter: top level with the row of store cells.
//
// Input stream s_axis: one set element per request in tdata, tlast marks the
// final element of the set. Output stream m_axis: one result per element with
// the element and the running distinct count in tdata, keep and overflow
// flags in tuser, and tlast copied from the input.
// An accepted element sits in a hold register while every cell
// of the store row compares it against its kept value; the OR of the cell
// hits decides keep, and a new value is shifted into the head of the row.
// The hold register feeds the result register, which takes the result only
// when it is free or its result is being taken.
// A new element is not accepted while one sits in the hold register, so the
// filter is through with each element before it takes another.
// When the row already holds CAPACITY values a new value is flagged as
// overflow and not stored. After the last element of a set the count returns
// to zero, which empties the row without touching the cells.
// Reset empties the store and drops any pending result. While the receiver
// stalls, the result register holds; one more element may be accepted and
// waits in the hold register until the result register frees up.
module stable_duplicate_filter_top #(
  parameter int CAPACITY   = 64,
  parameter int DATA_WIDTH = 32
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  // [31:0] value
  input  logic [sdf_pkg::S_DATA_W-1:0]    s_axis_tdata_i,
  input  logic                            s_axis_tlast_i,
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  // [31:0] value_out, [38:32] distinct_count, [39] zero
  output logic [sdf_pkg::M_DATA_W-1:0]    m_axis_tdata_o,
  // [0] keep, [1] overflow
  output logic [sdf_pkg::M_USER_W-1:0]    m_axis_tuser_o,
  output logic                            m_axis_tlast_o
);

  import sdf_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);

  logic               busy_q;
  logic [VALUE_W-1:0] item_value_q;
  logic               item_last_q;
  logic [CW-1:0]      count_q;
  logic [CW-1:0]      count_d;
  logic [CW-1:0]      count_next;

  logic               out_valid_q;
  logic [VALUE_W-1:0] out_value_q;
  logic [COUNT_W-1:0] out_count_q;
  out_user_t          out_user_q;
  out_user_t          out_user_d;
  logic               out_last_q;

  logic                  accept;
  logic                  finish;
  logic                  hit;
  logic                  full;
  logic                  insert;
  logic [DATA_WIDTH-1:0] probe;
  logic [CAPACITY-1:0]   hits;
  logic [CAPACITY-1:0]   active;
  logic [DATA_WIDTH-1:0] chain [CAPACITY+1];

  assign s_axis_tready_o = !busy_q;
  assign accept = s_axis_tvalid_i && !busy_q;
  assign finish = busy_q && (!out_valid_q || m_axis_tready_i);

  assign probe  = DATA_WIDTH'(item_value_q);
  assign hit    = |hits;
  assign full   = (count_q == CW'(CAPACITY));
  assign insert = finish && !hit && !full;

  // Head of the row takes the new value; each cell hands its value down.
  assign chain[0] = probe;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    assign active[i] = (count_q > CW'(i));

    sdf_cell #(
      .DATA_WIDTH (DATA_WIDTH)
    ) u_cell (
      .clk_i    (clk_i),
      .shift_i  (insert),
      .data_i   (chain[i]),
      .probe_i  (probe),
      .active_i (active[i]),
      .data_o   (chain[i+1]),
      .hit_o    (hits[i])
    );
  end

  assign count_next = insert ? count_q + CW'(1) : count_q;

  always_comb begin
    count_d = count_q;
    if (finish) begin
      count_d = item_last_q ? '0 : count_next;
    end
  end

  assign out_user_d.keep     = !hit;
  assign out_user_d.overflow = !hit && full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        busy_q <= 1'b1;
      end else if (finish) begin
        busy_q <= 1'b0;
      end
      count_q <= count_d;
      if (finish) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_value_q <= s_axis_tdata_i[VALUE_W-1:0];
      item_last_q  <= s_axis_tlast_i;
    end
    if (finish) begin
      out_value_q <= item_value_q;
      out_count_q <= COUNT_W'(count_next);
      out_user_q  <= out_user_d;
      out_last_q  <= item_last_q;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{(M_DATA_W - VALUE_W - COUNT_W){1'b0}}, out_count_q, out_value_q};
  assign m_axis_tuser_o  = out_user_q;
  assign m_axis_tlast_o  = out_last_q;

endmodule

// ===== rtl/sdf_checker.sv =====
// Port-level checks of the duplicate filter, bound to the top level.
`include "stable_duplicate_filter_top_defines.svh"

module sdf_checker #(
  parameter int CAPACITY = 64
) (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         s_axis_tvalid_i,
  input logic                         s_axis_tready_o,
  input logic                         m_axis_tvalid_o,
  input logic                         m_axis_tready_i,
  input logic [sdf_pkg::M_DATA_W-1:0] m_axis_tdata_o,
  input logic [sdf_pkg::M_USER_W-1:0] m_axis_tuser_o
);

  import sdf_pkg::*;

  out_user_t          user;
  logic [COUNT_W-1:0] count;

  assign user  = m_axis_tuser_o;
  assign count = m_axis_tdata_o[VALUE_W +: COUNT_W];

  // A cycle spent in reset leaves no result behind it.
  `SDF_ASSERT_ALWAYS(a_no_result_in_reset, clk_i, !rst_ni |=> !m_axis_tvalid_o, "result valid after reset")

  `SDF_ASSERT(a_result_held, clk_i, rst_ni, m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o, "stalled result dropped")

  `SDF_ASSERT(a_busy_after_request, clk_i, rst_ni, s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o, "request taken while previous still in compare")

  `SDF_ASSERT(a_overflow_when_full, clk_i, rst_ni, m_axis_tvalid_o && user.overflow |-> user.keep && (count == COUNT_W'(CAPACITY)), "overflow without a full store")

endmodule

bind stable_duplicate_filter_top sdf_checker #(
  .CAPACITY (CAPACITY)
) u_sdf_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);
